// File: sv/psch_pkg.sv
package psch_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;

	localparam logic OP_ARRIVAL  = 1'b0;
	localparam logic OP_COMPLETE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] arrival;
		logic [15:0] total;
		logic [15:0] remaining;
		logic [7:0]  priority_n;
	} entry_t;

	typedef struct packed {
		logic latch;
		logic decide;
		logic scan;
		logic shift;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic empty;
		logic scan_end;
		logic shift_end;
		logic out_free;
	} status_t;

endpackage

// File: sv/preemptive_priority_scheduler.sv
// channel   handshake              payload
// in        in_valid / in_ready    operation, timestamp, proc_id, arrival_time,
//                                  total_burst, priority_req
// out       out_valid / out_ready  running_valid, run_id, run_arrival, run_total,
//                                  run_start, run_end, run_remaining, run_priority,
//                                  waiting_count, overflow
//
// Arrival, or completion on an empty queue: latch, decide, then publish.
// Completion with entries queued: latch, decide, scan for the minimum priority
// entry, close its gap over the separate read and write ports, then publish.
// One event in flight; the next transfer is taken once the result sits in the
// output register. Reset (arst_n) empties the queue and clears the run slot.
module preemptive_priority_scheduler
	import psch_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] timestamp,
	input  logic [15:0] proc_id,
	input  logic [31:0] arrival_time,
	input  logic [15:0] total_burst,
	input  logic [7:0]  priority_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        running_valid,
	output logic [15:0] run_id,
	output logic [31:0] run_arrival,
	output logic [15:0] run_total,
	output logic [31:0] run_start,
	output logic [31:0] run_end,
	output logic [15:0] run_remaining,
	output logic [7:0]  run_priority,
	output logic [4:0]  waiting_count,
	output logic        overflow
);

	cmd_t    cmd;
	status_t status;

	psch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	psch_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.operation     (operation),
		.timestamp     (timestamp),
		.proc_id       (proc_id),
		.arrival_time  (arrival_time),
		.total_burst   (total_burst),
		.priority_req  (priority_req),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.running_valid (running_valid),
		.run_id        (run_id),
		.run_arrival   (run_arrival),
		.run_total     (run_total),
		.run_start     (run_start),
		.run_end       (run_end),
		.run_remaining (run_remaining),
		.run_priority  (run_priority),
		.waiting_count (waiting_count),
		.overflow      (overflow)
	);

	// a dropped arrival needs a running process
	a_ovf_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> running_valid)
		else $error("overflow without running process");

	// empty run slot reads as zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running_valid |->
			run_id == 16'd0 && run_remaining == 16'd0 && run_priority == 8'd0)
		else $error("idle run slot not cleared");

	// one event at a time
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while busy");

endmodule

// File: sv/psch_ctrl.sv
module psch_ctrl
	import psch_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.op == OP_ARRIVAL || status.empty) state_nxt = ST_DONE;
				else state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_end) state_nxt = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (status.shift_end) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			ST_DECIDE: cmd.decide  = 1'b1;
			ST_SCAN:   cmd.scan    = 1'b1;
			ST_SHIFT:  cmd.shift   = 1'b1;
			ST_DONE:   cmd.publish = status.out_free;
			default:   cmd         = '0;
		endcase
	end

endmodule

// File: sv/psch_dp.sv
module psch_dp
	import psch_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        operation,
	input  logic [31:0] timestamp,
	input  logic [15:0] proc_id,
	input  logic [31:0] arrival_time,
	input  logic [15:0] total_burst,
	input  logic [7:0]  priority_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        running_valid,
	output logic [15:0] run_id,
	output logic [31:0] run_arrival,
	output logic [15:0] run_total,
	output logic [31:0] run_start,
	output logic [31:0] run_end,
	output logic [15:0] run_remaining,
	output logic [7:0]  run_priority,
	output logic [4:0]  waiting_count,
	output logic        overflow
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// latched event
	logic        op_q;
	logic [31:0] now_q;
	entry_t      new_q;

	// running process
	logic        cur_valid_q;
	entry_t      cur_q;
	logic [31:0] cur_start_q;
	logic [31:0] cur_end_q;
	logic [CW-1:0] size_q;
	logic        ovf_q;

	// queue memory
	entry_t      mem [QUEUE_DEPTH];
	entry_t      rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	entry_t      wr_data;
	logic        wr_en;

	logic [CW-1:0] k_q;
	logic [CW-1:0] sh_q;
	logic [AW-1:0] best_idx_q, best_idx_nxt;
	entry_t      best_q, best_nxt;

	logic [31:0] elapsed;
	logic [15:0] left;
	logic        full;
	logic        out_valid_q;
	logic        shift_wr;
	logic [CW:0] sh_ext, best_ext;

	assign full    = (size_q == CW'(QUEUE_DEPTH));
	assign elapsed = now_q - cur_start_q;
	assign left    = (elapsed < {16'd0, cur_q.remaining}) ?
	                 (cur_q.remaining - elapsed[15:0]) : 16'd0;

	assign sh_ext   = {1'b0, sh_q};
	assign best_ext = (CW+1)'(best_idx_q) + (CW+1)'(2);
	assign shift_wr = cmd.shift && (sh_ext >= best_ext);

	assign status.op        = op_q;
	assign status.empty     = (size_q == '0);
	assign status.scan_end  = (k_q == size_q);
	assign status.shift_end = (sh_q == size_q);
	assign status.out_free  = !out_valid_q || out_ready;

	// best-so-far over the scan; read data belongs to index k-1
	always_comb begin
		best_idx_nxt = best_idx_q;
		best_nxt     = best_q;
		if (cmd.scan && k_q != '0) begin
			if (k_q == CW'(1) || rd_q.priority_n < best_q.priority_n) begin
				best_idx_nxt = AW'(k_q - CW'(1));
				best_nxt     = rd_q;
			end
		end
	end

	always_comb begin
		rd_addr = cmd.scan ? k_q[AW-1:0] : sh_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = size_q[AW-1:0];
		wr_data = new_q;
		if (cmd.decide && op_q == OP_ARRIVAL && cur_valid_q && !full) begin
			wr_en = 1'b1;
			if (new_q.priority_n < cur_q.priority_n) begin
				wr_data           = cur_q;
				wr_data.remaining = left;
			end
		end else if (shift_wr) begin
			wr_en   = 1'b1;
			wr_addr = AW'(sh_q - CW'(2));
			wr_data = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q                 <= operation;
			now_q                <= timestamp;
			new_q.id             <= proc_id;
			new_q.arrival        <= arrival_time;
			new_q.total          <= total_burst;
			new_q.remaining      <= total_burst;
			new_q.priority_n     <= priority_req;
		end
		if (cmd.decide) k_q <= '0;
		else if (cmd.scan) k_q <= k_q + CW'(1);
		if (cmd.scan) begin
			best_idx_q <= best_idx_nxt;
			best_q     <= best_nxt;
			sh_q       <= CW'(best_idx_nxt) + CW'(1);
		end else if (cmd.shift) begin
			sh_q <= sh_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			cur_start_q <= '0;
			cur_end_q   <= '0;
			size_q      <= '0;
			ovf_q       <= 1'b0;
		end else if (cmd.decide) begin
			ovf_q <= 1'b0;
			if (op_q == OP_ARRIVAL) begin
				if (!cur_valid_q || (!full && new_q.priority_n < cur_q.priority_n)) begin
					cur_valid_q <= 1'b1;
					cur_q       <= new_q;
					cur_start_q <= now_q;
					cur_end_q   <= now_q + {16'd0, new_q.remaining};
				end
				if (cur_valid_q && full) ovf_q <= 1'b1;
				if (cur_valid_q && !full) size_q <= size_q + CW'(1);
			end else if (size_q == '0) begin
				cur_valid_q <= 1'b0;
				cur_q       <= '0;
				cur_start_q <= '0;
				cur_end_q   <= '0;
			end
		end else if (cmd.shift && sh_q == size_q) begin
			cur_valid_q <= 1'b1;
			cur_q       <= best_q;
			cur_start_q <= now_q;
			cur_end_q   <= now_q + {16'd0, best_q.remaining};
			size_q      <= size_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			running_valid <= cur_valid_q;
			run_id        <= cur_q.id;
			run_arrival   <= cur_q.arrival;
			run_total     <= cur_q.total;
			run_start     <= cur_start_q;
			run_end       <= cur_end_q;
			run_remaining <= cur_q.remaining;
			run_priority  <= cur_q.priority_n;
			waiting_count <= 5'(size_q);
			overflow      <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
